FILE: design/kioj_pkg.sv
// Shared constants and types for the keyed interval overlap join unit.
package kioj_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 16;
   localparam int COORD_W     = 32;
   localparam int QROW_W      = 16;
   localparam int ROW_W       = 6;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic        [KEY_W-1:0]   key;
      logic signed [COORD_W-1:0] start;
      logic signed [COORD_W-1:0] stop;
   } kioj_row_type;

endpackage

FILE: design/kioj_table.sv
// Interval table memory: one write port, one registered read port.
module kioj_table
   import kioj_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  kioj_row_type       wr_row,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output kioj_row_type       rd_row
);

   kioj_row_type mem_ff [TABLE_DEPTH];
   kioj_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: design/keyed_interval_overlap_join_unit.sv
// Top level of the keyed interval overlap join unit: sequencer, compare unit and result register.
//
//   channel   direction  handshake             payload
//   request   in         start && !busy        req_operation, req_range_key, req_range_start,
//                                              req_range_end, req_query_row
//   result    out        rsp_valid, 1 cycle    rsp_query_row_echo, rsp_match_row, rsp_matched,
//                                              rsp_table_full, rsp_last
//
// Clear and load do not raise busy; a dropped load shows its result on the next cycle.
// A query holds busy through ST_SCAN and ST_FINAL: one table row is read and compared per cycle
// through the single read port of the table memory, then ST_FINAL closes the scan.
// Results of a query come out during the scan, the last one in the same cycle as busy falls.
// Reset is synchronous and empties the table; stored rows need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_interval_overlap_join_unit
   import kioj_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [KEY_W-1:0]          req_range_key,
   input  logic signed [COORD_W-1:0] req_range_start,
   input  logic signed [COORD_W-1:0] req_range_end,
   input  logic [QROW_W-1:0]         req_query_row,
   output logic                      rsp_valid,
   output logic [QROW_W-1:0]         rsp_query_row_echo,
   output logic [ROW_W-1:0]          rsp_match_row,
   output logic                      rsp_matched,
   output logic                      rsp_table_full,
   output logic                      rsp_last
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINAL} state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]         rd_tag_ff, rd_tag_in;
   logic [KEY_W-1:0]          q_key_ff, q_key_in;
   logic signed [COORD_W-1:0] q_start_ff, q_start_in;
   logic signed [COORD_W-1:0] q_end_ff, q_end_in;
   logic [QROW_W-1:0]         q_row_ff, q_row_in;
   logic                      q_order_ff, q_order_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]         pend_row_ff, pend_row_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [QROW_W-1:0]         rsp_echo_ff, rsp_echo_in;
   logic [ROW_W-1:0]          rsp_row_ff, rsp_row_in;
   logic                      rsp_matched_ff, rsp_matched_in;
   logic                      rsp_full_ff, rsp_full_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      wr_en;
   logic                      rd_en;
   kioj_row_type              wr_row;
   kioj_row_type              rd_row;
   logic                      hit;

   assign wr_row.key   = req_range_key;
   assign wr_row.start = req_range_start;
   assign wr_row.stop  = req_range_end;

   kioj_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_row  (wr_row),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_row  (rd_row)
   );

   assign hit = rd_valid_ff && (rd_row.key == q_key_ff) && q_order_ff
                && (q_end_ff >= rd_row.start) && (rd_row.stop >= q_start_ff)
                && (rd_row.stop >= rd_row.start);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      rd_valid_in    = 1'b0;
      rd_tag_in      = rd_tag_ff;
      q_key_in       = q_key_ff;
      q_start_in     = q_start_ff;
      q_end_in       = q_end_ff;
      q_row_in       = q_row_ff;
      q_order_in     = q_order_ff;
      pend_valid_in  = pend_valid_ff;
      pend_row_in    = pend_row_ff;
      rsp_valid_in   = 1'b0;
      rsp_echo_in    = rsp_echo_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LOAD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_valid_in   = 1'b1;
                        rsp_echo_in    = '0;
                        rsp_row_in     = '0;
                        rsp_matched_in = 1'b0;
                        rsp_full_in    = 1'b1;
                        rsp_last_in    = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     q_key_in      = req_range_key;
                     q_start_in    = req_range_start;
                     q_end_in      = req_range_end;
                     q_row_in      = req_query_row;
                     q_order_in    = (req_range_end >= req_range_start);
                     scan_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_tag_in   = scan_ff[ADDR_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end else begin
               state_in = ST_FINAL;
            end
            if (hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_echo_in    = q_row_ff;
                  rsp_row_in     = ROW_W'(pend_row_ff);
                  rsp_matched_in = 1'b1;
                  rsp_full_in    = 1'b0;
                  rsp_last_in    = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_row_in   = rd_tag_ff;
            end
         end
         ST_FINAL: begin
            rsp_valid_in   = 1'b1;
            rsp_echo_in    = q_row_ff;
            rsp_row_in     = pend_valid_ff ? ROW_W'(pend_row_ff) : '0;
            rsp_matched_in = pend_valid_ff;
            rsp_full_in    = 1'b0;
            rsp_last_in    = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_tag_ff      <= rd_tag_in;
      q_key_ff       <= q_key_in;
      q_start_ff     <= q_start_in;
      q_end_ff       <= q_end_in;
      q_row_ff       <= q_row_in;
      q_order_ff     <= q_order_in;
      pend_row_ff    <= pend_row_in;
      rsp_echo_ff    <= rsp_echo_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_query_row_echo = rsp_echo_ff;
   assign rsp_match_row      = rsp_row_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

FILE: design/kioj_checker.sv
// Port-level checker for the keyed interval overlap join unit, with its bind.
module kioj_protocol_checker
   import kioj_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [OP_W-1:0]           req_operation,
   input logic                      rsp_valid,
   input logic                      rsp_matched,
   input logic                      rsp_table_full,
   input logic                      rsp_last
);

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_QUERY) |=> busy)
      else $error("query accepted but unit not busy");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == OP_CLEAR) |=> !busy && !rsp_valid)
      else $error("clear produced a result or busy cycle");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   a_full_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_last && !rsp_matched)
      else $error("table-full result malformed");

   a_unmatched_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_last)
      else $error("unmatched result not final");

endmodule

bind keyed_interval_overlap_join_unit kioj_protocol_checker u_kioj_protocol_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_matched    (rsp_matched),
   .rsp_table_full (rsp_table_full),
   .rsp_last       (rsp_last)
);
